/* rtl/core/ttsl_pkg.sv */
`timescale 1ns / 1ps

package ttsl_pkg;

   localparam int CODE_W = 8;
   localparam int RATE_W = 10;
   localparam int LIMIT_W = 19;
   localparam int MS_W = 16;
   localparam int POS_W = 20;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 19;

   // Product of rate and milliseconds, and the integration sum that holds it.
   localparam int PROD_W = RATE_W + MS_W;
   localparam int SUM_W = PROD_W + 2;

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_SET  = 2'd1,
      CMD_STOP = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      AXIS_HORIZ = 2'd0,
      AXIS_VERT  = 2'd1,
      AXIS_BAD2  = 2'd2,
      AXIS_BAD3  = 2'd3
   } axis_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CODE_FAST_CW  = 3'd0,
      CSR_CODE_SLOW_CW  = 3'd1,
      CSR_CODE_STOP     = 3'd2,
      CSR_CODE_SLOW_CCW = 3'd3,
      CSR_CODE_FAST_CCW = 3'd4,
      CSR_FAST_RATE     = 3'd5,
      CSR_SLOW_RATE     = 3'd6,
      CSR_TRAVEL_LIMIT  = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic [CODE_W-1:0]  code_fast_cw;
      logic [CODE_W-1:0]  code_slow_cw;
      logic [CODE_W-1:0]  code_stop;
      logic [CODE_W-1:0]  code_slow_ccw;
      logic [CODE_W-1:0]  code_fast_ccw;
      logic [RATE_W-1:0]  fast_rate;
      logic [RATE_W-1:0]  slow_rate;
      logic [LIMIT_W-1:0] travel_limit;
   } cfg_type;

   localparam logic [CODE_W-1:0]  RST_CODE_FAST_CW  = 8'd0;
   localparam logic [CODE_W-1:0]  RST_CODE_SLOW_CW  = 8'd80;
   localparam logic [CODE_W-1:0]  RST_CODE_STOP     = 8'd90;
   localparam logic [CODE_W-1:0]  RST_CODE_SLOW_CCW = 8'd100;
   localparam logic [CODE_W-1:0]  RST_CODE_FAST_CCW = 8'd180;
   localparam logic [RATE_W-1:0]  RST_FAST_RATE     = 10'd60;
   localparam logic [RATE_W-1:0]  RST_SLOW_RATE     = 10'd20;
   localparam logic [LIMIT_W-1:0] RST_TRAVEL_LIMIT  = 19'd90000;

   typedef struct packed {
      logic              neg;
      logic [RATE_W-1:0] mag;
   } rate_type;

   typedef struct packed {
      logic integrate;
      logic set;
      logic stop;
   } axis_ctrl_type;

   // First matching code wins; an unmatched code means no motion.
   function automatic rate_type code_rate(cfg_type cfg, logic [CODE_W-1:0] code);
      rate_type r;
      r.neg = 1'b0;
      r.mag = '0;
      if (code == cfg.code_fast_cw) begin
         r.neg = 1'b1;
         r.mag = cfg.fast_rate;
      end else if (code == cfg.code_slow_cw) begin
         r.neg = 1'b1;
         r.mag = cfg.slow_rate;
      end else if (code == cfg.code_stop) begin
         r.mag = '0;
      end else if (code == cfg.code_slow_ccw) begin
         r.mag = cfg.slow_rate;
      end else if (code == cfg.code_fast_ccw) begin
         r.mag = cfg.fast_rate;
      end
      return r;
   endfunction

endpackage

/* rtl/core/two_axis_turret_soft_limit_core.sv */
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  cmd, elapsed_ms, axis, drive_code
// rsp      out        rsp_valid/rsp_stall  accepted, drives, positions
// csr      in         csr_wr_en            csr_index, csr_wdata
//
// A word is registered on entry, its result in the result register; one word per
// cycle sustained unless the result stalls, set by the combinational multiply-add-clamp of each axis.
// Reset is synchronous: positions clear, drives load the stop code, registers
// take their defaults. The drive and position registers are the result register,
// so they only update when the result slot is free; a stalled result still lets
// one more word wait in the input register.

module two_axis_turret_soft_limit_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_cmd,
   input  logic [ttsl_pkg::MS_W-1:0]            req_elapsed_ms,
   input  logic [1:0]                           req_axis,
   input  logic [ttsl_pkg::CODE_W-1:0]          req_drive_code,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_accepted,
   output logic [ttsl_pkg::CODE_W-1:0]          rsp_horiz_drive,
   output logic [ttsl_pkg::CODE_W-1:0]          rsp_vert_drive,
   output logic signed [ttsl_pkg::POS_W-1:0]    rsp_horiz_position,
   output logic signed [ttsl_pkg::POS_W-1:0]    rsp_vert_position,
   input  logic                                 csr_wr_en,
   input  logic [ttsl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ttsl_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   ttsl_pkg::cfg_type                  cfg;

   logic                               s1_valid_ff;
   ttsl_pkg::cmd_type                  cmd_ff;
   logic [ttsl_pkg::MS_W-1:0]          ms_ff;
   ttsl_pkg::axis_type                 axis_ff;
   logic [ttsl_pkg::CODE_W-1:0]        code_ff;

   logic                               rsp_valid_ff;
   logic                               accepted_ff;
   logic                               accepted_in;
   logic signed [ttsl_pkg::POS_W-1:0]  horiz_pos_ff;
   logic signed [ttsl_pkg::POS_W-1:0]  vert_pos_ff;
   logic [ttsl_pkg::CODE_W-1:0]        horiz_drive_ff;
   logic [ttsl_pkg::CODE_W-1:0]        vert_drive_ff;
   logic signed [ttsl_pkg::POS_W-1:0]  horiz_pos_in;
   logic signed [ttsl_pkg::POS_W-1:0]  vert_pos_in;
   logic [ttsl_pkg::CODE_W-1:0]        horiz_drive_in;
   logic [ttsl_pkg::CODE_W-1:0]        vert_drive_in;

   ttsl_pkg::axis_ctrl_type            horiz_ctrl;
   ttsl_pkg::axis_ctrl_type            vert_ctrl;
   logic                               advance;
   logic                               req_take;
   logic                               is_set;

   ttsl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign is_set = (cmd_ff == ttsl_pkg::CMD_SET);

   always_comb begin
      horiz_ctrl.integrate = (cmd_ff == ttsl_pkg::CMD_TICK) || is_set;
      horiz_ctrl.set       = is_set && (axis_ff == ttsl_pkg::AXIS_HORIZ);
      horiz_ctrl.stop      = (cmd_ff == ttsl_pkg::CMD_STOP);
      vert_ctrl.integrate  = horiz_ctrl.integrate;
      vert_ctrl.set        = is_set && (axis_ff == ttsl_pkg::AXIS_VERT);
      vert_ctrl.stop       = horiz_ctrl.stop;
      accepted_in = !(is_set && (axis_ff != ttsl_pkg::AXIS_HORIZ) &&
                      (axis_ff != ttsl_pkg::AXIS_VERT));
   end

   ttsl_axis u_horiz (
      .cfg        (cfg),
      .ctrl       (horiz_ctrl),
      .elapsed_ms (ms_ff),
      .drive_code (code_ff),
      .pos        (horiz_pos_ff),
      .drive      (horiz_drive_ff),
      .pos_next   (horiz_pos_in),
      .drive_next (horiz_drive_in)
   );

   ttsl_axis u_vert (
      .cfg        (cfg),
      .ctrl       (vert_ctrl),
      .elapsed_ms (ms_ff),
      .drive_code (code_ff),
      .pos        (vert_pos_ff),
      .drive      (vert_drive_ff),
      .pos_next   (vert_pos_in),
      .drive_next (vert_drive_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff  <= ttsl_pkg::cmd_type'(req_cmd);
         ms_ff   <= req_elapsed_ms;
         axis_ff <= ttsl_pkg::axis_type'(req_axis);
         code_ff <= req_drive_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         horiz_pos_ff   <= '0;
         vert_pos_ff    <= '0;
         horiz_drive_ff <= ttsl_pkg::RST_CODE_STOP;
         vert_drive_ff  <= ttsl_pkg::RST_CODE_STOP;
      end else begin
         if (advance) begin
            rsp_valid_ff   <= 1'b1;
            horiz_pos_ff   <= horiz_pos_in;
            vert_pos_ff    <= vert_pos_in;
            horiz_drive_ff <= horiz_drive_in;
            vert_drive_ff  <= vert_drive_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         accepted_ff <= accepted_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = accepted_ff;
   assign rsp_horiz_drive    = horiz_drive_ff;
   assign rsp_vert_drive     = vert_drive_ff;
   assign rsp_horiz_position = horiz_pos_ff;
   assign rsp_vert_position  = vert_pos_ff;

   // A stop word leaves both positions where they were and both drives stopped.
   a_stop_holds_pos: assert property (@(posedge clock) disable iff (reset)
      advance && (cmd_ff == ttsl_pkg::CMD_STOP)
      |=> $stable(horiz_pos_ff) && $stable(vert_pos_ff))
      else $error("stop word moved a position");

   a_stop_drives: assert property (@(posedge clock) disable iff (reset)
      advance && (cmd_ff == ttsl_pkg::CMD_STOP)
      |=> (horiz_drive_ff == $past(cfg.code_stop)) && (vert_drive_ff == $past(cfg.code_stop)))
      else $error("stop word did not load the stop code");

   // After integrating, the horizontal position is inside the travel limit.
   a_horiz_in_limit: assert property (@(posedge clock) disable iff (reset)
      advance && horiz_ctrl.integrate
      |=> ((ttsl_pkg::POS_W+1)'(horiz_pos_ff) <= $signed({2'b00, $past(cfg.travel_limit)})) &&
          ((ttsl_pkg::POS_W+1)'(horiz_pos_ff) >= -$signed({2'b00, $past(cfg.travel_limit)})))
      else $error("horizontal position beyond travel limit");

   // Results only move while the result slot is free or being drained.
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(horiz_pos_ff) && $stable(vert_drive_ff))
      else $error("result state changed under stall");

endmodule

/* rtl/core/ttsl_csr.sv */
`timescale 1ns / 1ps

module ttsl_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [ttsl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ttsl_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output ttsl_pkg::cfg_type                    cfg
);

   ttsl_pkg::cfg_type cfg_ff;
   ttsl_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (ttsl_pkg::csr_idx_type'(csr_index))
            ttsl_pkg::CSR_CODE_FAST_CW:  cfg_in.code_fast_cw  = csr_wdata[ttsl_pkg::CODE_W-1:0];
            ttsl_pkg::CSR_CODE_SLOW_CW:  cfg_in.code_slow_cw  = csr_wdata[ttsl_pkg::CODE_W-1:0];
            ttsl_pkg::CSR_CODE_STOP:     cfg_in.code_stop     = csr_wdata[ttsl_pkg::CODE_W-1:0];
            ttsl_pkg::CSR_CODE_SLOW_CCW: cfg_in.code_slow_ccw = csr_wdata[ttsl_pkg::CODE_W-1:0];
            ttsl_pkg::CSR_CODE_FAST_CCW: cfg_in.code_fast_ccw = csr_wdata[ttsl_pkg::CODE_W-1:0];
            ttsl_pkg::CSR_FAST_RATE:     cfg_in.fast_rate     = csr_wdata[ttsl_pkg::RATE_W-1:0];
            ttsl_pkg::CSR_SLOW_RATE:     cfg_in.slow_rate     = csr_wdata[ttsl_pkg::RATE_W-1:0];
            ttsl_pkg::CSR_TRAVEL_LIMIT:  cfg_in.travel_limit  = csr_wdata[ttsl_pkg::LIMIT_W-1:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_fast_cw  <= ttsl_pkg::RST_CODE_FAST_CW;
         cfg_ff.code_slow_cw  <= ttsl_pkg::RST_CODE_SLOW_CW;
         cfg_ff.code_stop     <= ttsl_pkg::RST_CODE_STOP;
         cfg_ff.code_slow_ccw <= ttsl_pkg::RST_CODE_SLOW_CCW;
         cfg_ff.code_fast_ccw <= ttsl_pkg::RST_CODE_FAST_CCW;
         cfg_ff.fast_rate     <= ttsl_pkg::RST_FAST_RATE;
         cfg_ff.slow_rate     <= ttsl_pkg::RST_SLOW_RATE;
         cfg_ff.travel_limit  <= ttsl_pkg::RST_TRAVEL_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/ttsl_axis.sv */
`timescale 1ns / 1ps

module ttsl_axis (
   input  ttsl_pkg::cfg_type                    cfg,
   input  ttsl_pkg::axis_ctrl_type              ctrl,
   input  logic [ttsl_pkg::MS_W-1:0]            elapsed_ms,
   input  logic [ttsl_pkg::CODE_W-1:0]          drive_code,
   input  logic signed [ttsl_pkg::POS_W-1:0]    pos,
   input  logic [ttsl_pkg::CODE_W-1:0]          drive,
   output logic signed [ttsl_pkg::POS_W-1:0]    pos_next,
   output logic [ttsl_pkg::CODE_W-1:0]          drive_next
);

   localparam int SUM_W = ttsl_pkg::SUM_W;
   localparam int POS_W = ttsl_pkg::POS_W;

   ttsl_pkg::rate_type                 cur_rate;
   ttsl_pkg::rate_type                 req_rate;
   logic [ttsl_pkg::PROD_W-1:0]        prod;
   logic signed [SUM_W-1:0]            pos_ext;
   logic signed [SUM_W-1:0]            prod_ext;
   logic signed [SUM_W-1:0]            lim_ext;
   logic signed [SUM_W-1:0]            neg_lim_ext;
   logic signed [SUM_W-1:0]            sum;
   logic                               neg_hit;
   logic                               pos_hit;
   logic signed [POS_W-1:0]            int_pos;
   logic [ttsl_pkg::CODE_W-1:0]        int_drive;
   logic signed [POS_W:0]              int_pos_ext;
   logic signed [POS_W:0]              lim_cmp;
   logic                               refuse;

   assign cur_rate = ttsl_pkg::code_rate(cfg, drive);
   assign req_rate = ttsl_pkg::code_rate(cfg, drive_code);

   assign prod     = ttsl_pkg::PROD_W'(cur_rate.mag) * ttsl_pkg::PROD_W'(elapsed_ms);
   assign pos_ext  = SUM_W'(pos);
   assign prod_ext = $signed({2'b00, prod});
   assign lim_ext  = $signed({{(SUM_W-ttsl_pkg::LIMIT_W){1'b0}}, cfg.travel_limit});
   assign neg_lim_ext = -lim_ext;
   assign sum      = cur_rate.neg ? (pos_ext - prod_ext) : (pos_ext + prod_ext);

   // A zero limit always trips the positive side; the axis then settles at zero.
   assign neg_hit = (sum <= neg_lim_ext);
   assign pos_hit = (sum >= lim_ext) || (neg_hit && (cfg.travel_limit == '0));

   always_comb begin
      int_pos   = pos;
      int_drive = drive;
      if (ctrl.integrate) begin
         if (pos_hit) begin
            int_pos   = lim_ext[POS_W-1:0];
            int_drive = cfg.code_stop;
         end else if (neg_hit) begin
            int_pos   = neg_lim_ext[POS_W-1:0];
            int_drive = cfg.code_stop;
         end else begin
            int_pos = sum[POS_W-1:0];
         end
      end
   end

   assign int_pos_ext = (POS_W+1)'(int_pos);
   assign lim_cmp     = $signed({2'b00, cfg.travel_limit});
   assign refuse = ((int_pos_ext <= -lim_cmp) && req_rate.neg && (req_rate.mag != '0)) ||
                   ((int_pos_ext >= lim_cmp) && !req_rate.neg && (req_rate.mag != '0));

   always_comb begin
      pos_next   = int_pos;
      drive_next = int_drive;
      if (ctrl.stop) begin
         drive_next = cfg.code_stop;
      end else if (ctrl.set) begin
         drive_next = refuse ? cfg.code_stop : drive_code;
      end
   end

endmodule
